// ----- rtl/rltt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log tracker package
// Shared widths, result and error codes, register indexes, and the control
// word that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package rltt_pkg;

  localparam int LOG_ENTRIES_DEF = 30;

  localparam int ACT_W   = 2;
  localparam int BLK_W   = 32;
  localparam int KIND_W  = 4;
  localparam int ERR_W   = 2;
  localparam int CNT_W   = 5;
  localparam int AREA_W  = 11;
  localparam int MAXOP_W = 5;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;
  localparam int UPC_W   = 5;
  localparam int COND_W  = 4;

  localparam logic [CNT_W-1:0] OPEN_MAX = 5'd31;

  localparam logic [BLK_W-1:0]   LOG_START_RST = 32'd2;
  localparam logic [AREA_W-1:0]  AREA_RST      = 11'd31;
  localparam logic [MAXOP_W-1:0] MAXOP_RST     = 5'd10;

  localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REC   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED = 4'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ENDED   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NEW     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ABSORB  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_COPY    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_HEADER  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_INSTALL = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 4'd8;

  localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OUTSIDE  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_BEGIN = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_LOG_START = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_AREA      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_OP    = 2'd2;

  localparam logic [1:0] FROM_ZERO  = 2'd0;
  localparam logic [1:0] FROM_RDATA = 2'd1;
  localparam logic [1:0] FROM_SLOT  = 2'd2;

  localparam logic [1:0] TO_ZERO   = 2'd0;
  localparam logic [1:0] TO_RDATA  = 2'd1;
  localparam logic [1:0] TO_SLOT   = 2'd2;
  localparam logic [1:0] TO_HEADER = 2'd3;

  localparam logic [1:0] CNT_TOTAL      = 2'd0;
  localparam logic [1:0] CNT_TOTAL_NEXT = 2'd1;
  localparam logic [1:0] CNT_ZERO       = 2'd2;

  localparam logic [1:0] IDX_HOLD  = 2'd0;
  localparam logic [1:0] IDX_CLEAR = 2'd1;
  localparam logic [1:0] IDX_INC   = 2'd2;

  localparam logic [1:0] OPEN_HOLD = 2'd0;
  localparam logic [1:0] OPEN_INC  = 2'd1;
  localparam logic [1:0] OPEN_DEC  = 2'd2;

  localparam logic [1:0] TOT_HOLD  = 2'd0;
  localparam logic [1:0] TOT_INC   = 2'd1;
  localparam logic [1:0] TOT_CLEAR = 2'd2;

  localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
  localparam logic [COND_W-1:0] C_ACT_BEGIN  = 4'd1;
  localparam logic [COND_W-1:0] C_ACT_END    = 4'd2;
  localparam logic [COND_W-1:0] C_ACT_REC    = 4'd3;
  localparam logic [COND_W-1:0] C_BEGIN_FULL = 4'd4;
  localparam logic [COND_W-1:0] C_OPEN_ZERO  = 4'd5;
  localparam logic [COND_W-1:0] C_NO_COMMIT  = 4'd6;
  localparam logic [COND_W-1:0] C_REC_FULL   = 4'd7;
  localparam logic [COND_W-1:0] C_MATCH      = 4'd8;
  localparam logic [COND_W-1:0] C_TOTAL_ZERO = 4'd9;

  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [1:0]        from_sel;
    logic [1:0]        to_sel;
    logic [1:0]        cnt_sel;
    logic              last;
    logic [1:0]        idx_op;
    logic [1:0]        open_op;
    logic [1:0]        tot_op;
    logic              mem_we;
    logic [COND_W-1:0] cond;
    logic              rpt;
    logic              done;
    logic [UPC_W-1:0]  target;
  } ctl_t;

  typedef struct packed {
    logic act_begin;
    logic act_end;
    logic act_rec;
    logic begin_full;
    logic open_zero;
    logic no_commit;
    logic rec_full;
    logic match;
    logic total_zero;
    logic idx_last;
  } flags_t;

endpackage

// ----- rtl/rltt_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log tracker sequencer
// Step counter over a control store; one control word per step, conditional
// jumps on datapath flags and a repeat-until-last-entry mode for table walks.
// ----------------------------------------------------------------------------
module rltt_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rltt_pkg::flags_t flags,
  output logic            busy,
  output logic            accept,
  output rltt_pkg::ctl_t  ctl
);
  import rltt_pkg::*;

  localparam logic [UPC_W-1:0] S_BEG    = 5'd4;
  localparam logic [UPC_W-1:0] S_WAIT   = 5'd6;
  localparam logic [UPC_W-1:0] S_END0   = 5'd7;
  localparam logic [UPC_W-1:0] S_ENDED  = 5'd14;
  localparam logic [UPC_W-1:0] S_ERR2   = 5'd15;
  localparam logic [UPC_W-1:0] S_REC0   = 5'd16;
  localparam logic [UPC_W-1:0] S_APPEND = 5'd20;
  localparam logic [UPC_W-1:0] S_ABSORB = 5'd21;
  localparam logic [UPC_W-1:0] S_ERR0   = 5'd22;
  localparam logic [UPC_W-1:0] S_ERR1   = 5'd23;

  function automatic ctl_t rom(input logic [UPC_W-1:0] a);
    ctl_t c;
    c = '0;
    case (a)
      5'd0: begin c.cond = C_ACT_BEGIN; c.target = S_BEG; end
      5'd1: begin c.cond = C_ACT_END; c.target = S_END0; end
      5'd2: begin c.cond = C_ACT_REC; c.target = S_REC0; end
      5'd3: begin c.done = 1'b1; end
      5'd4: begin c.cond = C_BEGIN_FULL; c.target = S_WAIT; end
      5'd5: begin
        c.emit = 1'b1; c.kind = KIND_GRANTED; c.last = 1'b1;
        c.open_op = OPEN_INC; c.done = 1'b1;
      end
      5'd6: begin c.emit = 1'b1; c.kind = KIND_WAIT; c.last = 1'b1; c.done = 1'b1; end
      5'd7: begin c.cond = C_OPEN_ZERO; c.target = S_ERR2; end
      5'd8: begin c.cond = C_NO_COMMIT; c.target = S_ENDED; end
      5'd9: begin c.open_op = OPEN_DEC; c.idx_op = IDX_CLEAR; end
      5'd10: begin
        c.emit = 1'b1; c.kind = KIND_COPY; c.from_sel = FROM_RDATA;
        c.to_sel = TO_SLOT; c.idx_op = IDX_INC; c.rpt = 1'b1;
      end
      5'd11: begin
        c.emit = 1'b1; c.kind = KIND_HEADER; c.to_sel = TO_HEADER;
        c.idx_op = IDX_CLEAR;
      end
      5'd12: begin
        c.emit = 1'b1; c.kind = KIND_INSTALL; c.from_sel = FROM_SLOT;
        c.to_sel = TO_RDATA; c.idx_op = IDX_INC; c.rpt = 1'b1;
      end
      5'd13: begin
        c.emit = 1'b1; c.kind = KIND_HEADER; c.to_sel = TO_HEADER;
        c.cnt_sel = CNT_ZERO; c.last = 1'b1; c.tot_op = TOT_CLEAR; c.done = 1'b1;
      end
      5'd14: begin
        c.emit = 1'b1; c.kind = KIND_ENDED; c.last = 1'b1;
        c.open_op = OPEN_DEC; c.done = 1'b1;
      end
      5'd15: begin
        c.emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_NO_BEGIN;
        c.last = 1'b1; c.done = 1'b1;
      end
      5'd16: begin c.cond = C_REC_FULL; c.target = S_ERR0; end
      5'd17: begin c.cond = C_OPEN_ZERO; c.target = S_ERR1; end
      5'd18: begin c.idx_op = IDX_CLEAR; c.cond = C_TOTAL_ZERO; c.target = S_APPEND; end
      5'd19: begin
        c.cond = C_MATCH; c.target = S_ABSORB; c.idx_op = IDX_INC; c.rpt = 1'b1;
      end
      5'd20: begin
        c.emit = 1'b1; c.kind = KIND_NEW; c.cnt_sel = CNT_TOTAL_NEXT;
        c.last = 1'b1; c.mem_we = 1'b1; c.tot_op = TOT_INC; c.done = 1'b1;
      end
      5'd21: begin c.emit = 1'b1; c.kind = KIND_ABSORB; c.last = 1'b1; c.done = 1'b1; end
      5'd22: begin
        c.emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_TOO_BIG;
        c.last = 1'b1; c.done = 1'b1;
      end
      5'd23: begin
        c.emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_OUTSIDE;
        c.last = 1'b1; c.done = 1'b1;
      end
      default: begin c.done = 1'b1; end
    endcase
    return c;
  endfunction

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             run_r, run_nxt;
  ctl_t             word;
  logic             taken;

  always_comb begin
    word = rom(upc_r);
    case (word.cond)
      C_ACT_BEGIN:  taken = flags.act_begin;
      C_ACT_END:    taken = flags.act_end;
      C_ACT_REC:    taken = flags.act_rec;
      C_BEGIN_FULL: taken = flags.begin_full;
      C_OPEN_ZERO:  taken = flags.open_zero;
      C_NO_COMMIT:  taken = flags.no_commit;
      C_REC_FULL:   taken = flags.rec_full;
      C_MATCH:      taken = flags.match;
      C_TOTAL_ZERO: taken = flags.total_zero;
      default:      taken = 1'b0;
    endcase
  end

  assign accept = start && !run_r;
  assign busy   = run_r;
  assign ctl    = run_r ? word : '0;

  always_comb begin
    upc_nxt = upc_r;
    run_nxt = run_r;
    if (!run_r) begin
      if (start) begin
        upc_nxt = '0;
        run_nxt = 1'b1;
      end
    end else if (word.done) begin
      upc_nxt = '0;
      run_nxt = 1'b0;
    end else if (taken) begin
      upc_nxt = word.target;
    end else if (word.rpt && !flags.idx_last) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= '0;
      run_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// ----- rtl/rltt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log tracker datapath
// Configuration registers, entry table memory, counters, condition flags and
// the registered result ports, all steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module rltt_datapath #(
  parameter int LOG_ENTRIES = rltt_pkg::LOG_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [rltt_pkg::ACT_W-1:0]    in_action,
  input  logic [rltt_pkg::BLK_W-1:0]    in_block_number,
  input  logic                          cfg_we,
  input  logic [rltt_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rltt_pkg::CDAT_W-1:0]   cfg_data,
  input  rltt_pkg::ctl_t                ctl,
  output rltt_pkg::flags_t              flags,
  output logic                          out_valid,
  output logic [rltt_pkg::KIND_W-1:0]   out_kind,
  output logic [rltt_pkg::ERR_W-1:0]    out_error_code,
  output logic [rltt_pkg::BLK_W-1:0]    out_from_block,
  output logic [rltt_pkg::BLK_W-1:0]    out_to_block,
  output logic [rltt_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_last
);
  import rltt_pkg::*;

  localparam int AW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

  logic [BLK_W-1:0]   log_start_r;
  logic [AREA_W-1:0]  area_r;
  logic [MAXOP_W-1:0] max_op_r;
  logic [ACT_W-1:0]   act_r;
  logic [BLK_W-1:0]   blk_r;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   open_r, open_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [BLK_W-1:0]   rdata_r;
  logic [BLK_W-1:0]   mem [LOG_ENTRIES];

  logic [CNT_W:0]     open_p1;
  logic [AREA_W-1:0]  prod;
  logic [AREA_W-1:0]  need;
  logic [BLK_W-1:0]   slot;
  logic [BLK_W-1:0]   from_v, to_v;
  logic [CNT_W-1:0]   cnt_v;

  logic               valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ERR_W-1:0]   err_r;
  logic [BLK_W-1:0]   from_r, to_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               last_r;

  always_comb begin
    case (ctl.idx_op)
      IDX_CLEAR: idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + 5'd1;
      default:   idx_nxt = idx_r;
    endcase
    case (ctl.open_op)
      OPEN_INC: open_nxt = open_r + 5'd1;
      OPEN_DEC: open_nxt = open_r - 5'd1;
      default:  open_nxt = open_r;
    endcase
    case (ctl.tot_op)
      TOT_INC:   total_nxt = total_r + 5'd1;
      TOT_CLEAR: total_nxt = '0;
      default:   total_nxt = total_r;
    endcase
  end

  always_comb begin
    open_p1 = {1'b0, open_r} + 6'd1;
    prod    = {5'b0, open_p1} * {6'b0, max_op_r};
    need    = prod + {6'b0, total_r};
    flags.act_begin  = (act_r == ACT_BEGIN);
    flags.act_end    = (act_r == ACT_END);
    flags.act_rec    = (act_r == ACT_REC);
    flags.begin_full = (open_r == OPEN_MAX) || (need > AREA_W'(LOG_ENTRIES));
    flags.open_zero  = (open_r == '0);
    flags.no_commit  = (open_r != 5'd1) || (total_r == '0);
    flags.rec_full   = ({1'b0, total_r} >= 6'(LOG_ENTRIES)) ||
                       ({6'b0, total_r} + 11'd1 >= area_r);
    flags.match      = (rdata_r == blk_r);
    flags.total_zero = (total_r == '0);
    flags.idx_last   = ({1'b0, idx_r} + 6'd1 >= {1'b0, total_r});
  end

  assign slot = log_start_r + {27'b0, idx_r} + 32'd1;

  always_comb begin
    case (ctl.from_sel)
      FROM_RDATA: from_v = rdata_r;
      FROM_SLOT:  from_v = slot;
      default:    from_v = '0;
    endcase
    case (ctl.to_sel)
      TO_RDATA:  to_v = rdata_r;
      TO_SLOT:   to_v = slot;
      TO_HEADER: to_v = log_start_r;
      default:   to_v = '0;
    endcase
    case (ctl.cnt_sel)
      CNT_TOTAL_NEXT: cnt_v = total_r + 5'd1;
      CNT_ZERO:       cnt_v = '0;
      default:        cnt_v = total_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_start_r <= LOG_START_RST;
      area_r      <= AREA_RST;
      max_op_r    <= MAXOP_RST;
      total_r     <= '0;
      open_r      <= '0;
      idx_r       <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG_START: log_start_r <= cfg_data;
          CFG_AREA:      area_r      <= cfg_data[AREA_W-1:0];
          CFG_MAX_OP:    max_op_r    <= cfg_data[MAXOP_W-1:0];
          default:       ;
        endcase
      end
      total_r <= total_nxt;
      open_r  <= open_nxt;
      idx_r   <= idx_nxt;
      valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      blk_r <= in_block_number;
    end
    kind_r <= ctl.kind;
    err_r  <= ctl.err;
    from_r <= from_v;
    to_r   <= to_v;
    cnt_r  <= cnt_v;
    last_r <= ctl.last;
  end

  // entry table: read data always tracks the entry at the next index
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[total_r[AW-1:0]] <= blk_r;
    end
    rdata_r <= mem[idx_nxt[AW-1:0]];
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_error_code  = err_r;
  assign out_from_block  = from_r;
  assign out_to_block    = to_r;
  assign out_entry_count = cnt_r;
  assign out_last        = last_r;

endmodule

// ----- rtl/redo_log_transaction_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log transaction tracker
// Results: a commit emits 2 * entries + 2 results back to back.
// Throughput: one item at a time; busy drops with the final result; results
//   cannot be stalled.
// Reset: synchronous, active low; counters cleared, registers to defaults.
// ----------------------------------------------------------------------------
module redo_log_transaction_tracker_top #(
  parameter int LOG_ENTRIES = rltt_pkg::LOG_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rltt_pkg::ACT_W-1:0]    in_action,
  input  logic [rltt_pkg::BLK_W-1:0]    in_block_number,
  input  logic                          cfg_we,
  input  logic [rltt_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [rltt_pkg::CDAT_W-1:0]   cfg_data,
  output logic                          out_valid,
  output logic [rltt_pkg::KIND_W-1:0]   out_kind,
  output logic [rltt_pkg::ERR_W-1:0]    out_error_code,
  output logic [rltt_pkg::BLK_W-1:0]    out_from_block,
  output logic [rltt_pkg::BLK_W-1:0]    out_to_block,
  output logic [rltt_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_last
);
  import rltt_pkg::*;

  ctl_t   ctl;
  flags_t flags;
  logic   accept;

  rltt_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .flags  (flags),
    .busy   (busy),
    .accept (accept),
    .ctl    (ctl)
  );

  rltt_datapath #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_action       (in_action),
    .in_block_number (in_block_number),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctl             (ctl),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_error_code  (out_error_code),
    .out_from_block  (out_from_block),
    .out_to_block    (out_to_block),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

// ----- rtl/rltt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log tracker checker
// Port-level properties of the command handshake and the result stream.
// ----------------------------------------------------------------------------
module rltt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [rltt_pkg::KIND_W-1:0] out_kind,
  input logic [rltt_pkg::ERR_W-1:0]  out_error_code,
  input logic                        out_last
);
  import rltt_pkg::*;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_in_work : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item at work");

  a_last_gap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after the final result of an item");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ERROR) |-> (out_error_code == ERR_TOO_BIG))
    else $error("error code set on a non-error result");

endmodule

bind redo_log_transaction_tracker_top rltt_checker u_rltt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_kind       (out_kind),
  .out_error_code (out_error_code),
  .out_last       (out_last)
);

// ----- test/rltt_commit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log tracker checker
// Watches the request, register and result ports of the tracker. It keeps
// its own copy of the entry table, the counters and the registers, works out
// the results that each accepted item should cause, and compares every
// result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module rltt_commit_checker #(
  parameter int LOG_ENTRIES = rltt_pkg::LOG_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rltt_pkg::ACT_W-1:0]  in_action,
  input  logic [rltt_pkg::BLK_W-1:0]  in_block_number,
  input  logic                        cfg_we,
  input  logic [rltt_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rltt_pkg::CDAT_W-1:0] cfg_data,
  input  logic                        out_valid,
  input  logic [rltt_pkg::KIND_W-1:0] out_kind,
  input  logic [rltt_pkg::ERR_W-1:0]  out_error_code,
  input  logic [rltt_pkg::BLK_W-1:0]  out_from_block,
  input  logic [rltt_pkg::BLK_W-1:0]  out_to_block,
  input  logic [rltt_pkg::CNT_W-1:0]  out_entry_count,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          outstanding,
  output int                          items_seen,
  output int                          results_seen,
  output int                          commits_seen
);
  import rltt_pkg::*;

  localparam logic [ERR_W-1:0] ERR_NONE = '0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [BLK_W-1:0]  from_blk;
    logic [BLK_W-1:0]  to_blk;
    logic [CNT_W-1:0]  count;
    logic              last;
  } log_result_t;

  log_result_t        pending_results[$];
  logic [BLK_W-1:0]   table_blocks [LOG_ENTRIES];
  logic [CNT_W-1:0]   held_total;
  logic [CNT_W-1:0]   open_count;
  logic [BLK_W-1:0]   log_base;
  logic [AREA_W-1:0]  area_blocks;
  logic [MAXOP_W-1:0] op_reserve;

  task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
                              input logic [BLK_W-1:0] from_blk,
                              input logic [BLK_W-1:0] to_blk,
                              input logic [CNT_W-1:0] count);
    log_result_t r;
    r.kind     = kind;
    r.err      = err;
    r.from_blk = from_blk;
    r.to_blk   = to_blk;
    r.count    = count;
    r.last     = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic predict_results(input logic [ACT_W-1:0] act, input logic [BLK_W-1:0] blk);
    int               base;
    logic [31:0]      need;
    logic [CNT_W-1:0] group;
    bit               found;
    base  = pending_results.size();
    found = 1'b0;
    if (act == ACT_BEGIN) begin
      need = 32'(held_total) + (32'(open_count) + 32'd1) * 32'(op_reserve);
      if (open_count >= OPEN_MAX || need > 32'(LOG_ENTRIES)) begin
        queue_result(KIND_WAIT, ERR_NONE, '0, '0, held_total);
      end else begin
        open_count = open_count + 1'b1;
        queue_result(KIND_GRANTED, ERR_NONE, '0, '0, held_total);
      end
    end else if (act == ACT_END) begin
      if (open_count == '0) begin
        queue_result(KIND_ERROR, ERR_NO_BEGIN, '0, '0, held_total);
      end else begin
        open_count = open_count - 1'b1;
        if (open_count == '0 && held_total != '0) begin
          group = held_total;
          for (int i = 0; i < int'(group) && i < LOG_ENTRIES; i++) begin
            queue_result(KIND_COPY, ERR_NONE, table_blocks[i], log_base + 32'd1 + 32'(i), group);
          end
          queue_result(KIND_HEADER, ERR_NONE, '0, log_base, group);
          for (int i = 0; i < int'(group) && i < LOG_ENTRIES; i++) begin
            queue_result(KIND_INSTALL, ERR_NONE, log_base + 32'd1 + 32'(i), table_blocks[i],
                         group);
          end
          queue_result(KIND_HEADER, ERR_NONE, '0, log_base, '0);
          held_total = '0;
          commits_seen++;
        end else begin
          queue_result(KIND_ENDED, ERR_NONE, '0, '0, held_total);
        end
      end
    end else if (act == ACT_REC) begin
      if (32'(held_total) >= 32'(LOG_ENTRIES) ||
          32'(held_total) + 32'd1 >= 32'(area_blocks)) begin
        queue_result(KIND_ERROR, ERR_TOO_BIG, '0, '0, held_total);
      end else if (open_count == '0) begin
        queue_result(KIND_ERROR, ERR_OUTSIDE, '0, '0, held_total);
      end else begin
        for (int i = 0; i < int'(held_total) && i < LOG_ENTRIES; i++) begin
          if (table_blocks[i] == blk) found = 1'b1;
        end
        if (found) begin
          queue_result(KIND_ABSORB, ERR_NONE, '0, '0, held_total);
        end else begin
          table_blocks[held_total] = blk;
          held_total = held_total + 1'b1;
          queue_result(KIND_NEW, ERR_NONE, '0, '0, held_total);
        end
      end
    end
    if (pending_results.size() > base) pending_results[pending_results.size()-1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      held_total   = '0;
      open_count   = '0;
      log_base     = LOG_START_RST;
      area_blocks  = AREA_RST;
      op_reserve   = MAXOP_RST;
      fail_count   = 0;
      items_seen   = 0;
      results_seen = 0;
      commits_seen = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d", $time, out_kind);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("error_code", want.err, out_error_code);
          check_field("from_block", want.from_blk, out_from_block);
          check_field("to_block", want.to_blk, out_to_block);
          check_field("entry_count", want.count, out_entry_count);
          check_field("last", want.last, out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOG_START: log_base = cfg_data;
          CFG_AREA: area_blocks = cfg_data[AREA_W-1:0];
          CFG_MAX_OP: op_reserve = cfg_data[MAXOP_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_action <= ACT_REC) items_seen++;
        predict_results(in_action, in_block_number);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- test/redo_log_transaction_tracker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Redo log transaction tracker testbench
// Drives begin, end and record requests into the tracker: a directed opening
// on the error paths, absorption, wrapped log slots and the smallest log,
// then a full table under the open-counter limit, then random transaction
// groups over several register settings. A side checker predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module redo_log_transaction_tracker_top_tb;
  import rltt_pkg::*;

  localparam int LOG_ENTRIES    = LOG_ENTRIES_DEF;
  localparam int DRAIN_CYCLES   = 2 * LOG_ENTRIES + 20;
  localparam int WATCHDOG_LIMIT = 3000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic [ACT_W-1:0]  in_action       = '0;
  logic [BLK_W-1:0]  in_block_number = '0;
  logic              cfg_we          = 1'b0;
  logic [CIDX_W-1:0] cfg_index       = '0;
  logic [CDAT_W-1:0] cfg_data        = '0;
  logic              busy;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [ERR_W-1:0]  out_error_code;
  logic [BLK_W-1:0]  out_from_block;
  logic [BLK_W-1:0]  out_to_block;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_last;

  int fail_count;
  int outstanding;
  int items_seen;
  int results_seen;
  int commits_seen;
  int cur_op_reserve = MAXOP_RST;
  int settings_used  = 1;
  bit idle_on        = 1'b1;
  int quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  redo_log_transaction_tracker_top #(.LOG_ENTRIES(LOG_ENTRIES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_block_number (in_block_number),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_error_code  (out_error_code),
    .out_from_block  (out_from_block),
    .out_to_block    (out_to_block),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  rltt_commit_checker #(.LOG_ENTRIES(LOG_ENTRIES)) u_commit_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_block_number (in_block_number),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_error_code  (out_error_code),
    .out_from_block  (out_from_block),
    .out_to_block    (out_to_block),
    .out_entry_count (out_entry_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .items_seen      (items_seen),
    .results_seen    (results_seen),
    .commits_seen    (commits_seen)
  );

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BLK_W-1:0] blk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_block_number <= blk;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender until every expected result is back, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [BLK_W-1:0] base, input logic [AREA_W-1:0] area,
                            input logic [MAXOP_W-1:0] reserve);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOG_START;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_AREA;
    cfg_data  <= CDAT_W'(area);
    @(posedge clk);
    cfg_index <= CFG_MAX_OP;
    cfg_data  <= CDAT_W'(reserve);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_op_reserve = reserve;
    settings_used++;
  endtask

  task automatic run_groups(input int n_items);
    int               sent;
    int               n_ops;
    int               n_end;
    int               cap;
    logic [BLK_W-1:0] blk;
    logic [ACT_W-1:0] act;
    logic [BLK_W-1:0] pool[$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if (cur_op_reserve == 0) cap = 3;
        else cap = LOG_ENTRIES / cur_op_reserve;
        if (cap > 3) cap = 3;
        if (cap < 1) cap = 1;
        n_ops = $urandom_range(1, cap);
        pool.delete();
        repeat (n_ops) begin
          send_item(ACT_BEGIN, $urandom);
          sent++;
        end
        repeat ($urandom_range(0, 12)) begin
          if (pool.size() != 0 && $urandom_range(0, 2) == 0) begin
            blk = pool[$urandom_range(0, pool.size() - 1)];
          end else begin
            blk = $urandom;
            pool.push_back(blk);
          end
          send_item(ACT_REC, blk);
          sent++;
        end
        case ($urandom_range(0, 7))
          0: n_end = n_ops + 1;
          1: n_end = n_ops - 1;
          default: n_end = n_ops;
        endcase
        repeat (n_end) begin
          send_item(ACT_END, $urandom);
          sent++;
        end
        if ($urandom_range(0, 9) == 0) drain();
      end else begin
        act = ACT_W'($urandom_range(0, 3));
        send_item(act, $urandom);
        if (act <= ACT_REC) sent++;
      end
    end
  endtask

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: error paths, reservation, absorption, commit at reset settings
    send_item(ACT_END, 32'h0000_0000);
    send_item(ACT_REC, 32'h0000_0000);
    send_item(ACT_W'(3), 32'hFFFF_FFFF);
    repeat (4) send_item(ACT_BEGIN, $urandom);
    send_item(ACT_REC, 32'h0000_0000);
    send_item(ACT_REC, 32'hFFFF_FFFF);
    send_item(ACT_REC, 32'hFFFF_FFFF);
    send_item(ACT_REC, 32'hA5A5_5A5A);
    repeat (3) send_item(ACT_END, $urandom);
    send_item(ACT_BEGIN, $urandom);
    send_item(ACT_END, $urandom);
    drain();

    // smallest log, widest reservation, slots wrapping past the top
    set_config(32'hFFFF_FFFF, 11'd2, 5'd30);
    send_item(ACT_BEGIN, $urandom);
    send_item(ACT_BEGIN, $urandom);
    send_item(ACT_REC, 32'h1234_5678);
    send_item(ACT_REC, 32'h1234_5678);
    send_item(ACT_END, $urandom);
    send_item(ACT_REC, 32'h5A5A_A5A5);
    drain();

    // no reservation: fill the open counter and the whole table
    set_config(32'h0000_0000, 11'd1024, 5'd0);
    repeat (OPEN_MAX + 1) send_item(ACT_BEGIN, $urandom);
    repeat (LOG_ENTRIES + 1) send_item(ACT_REC, $urandom);
    repeat (OPEN_MAX + 1) send_item(ACT_END, $urandom);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(32'h0000_0000, 11'd1024, 5'd1);
        1: set_config($urandom, 11'd2, 5'd30);
        7: begin
          idle_on = 1'b0;
          set_config(LOG_START_RST, AREA_RST, MAXOP_RST);
        end
        default: begin
          set_config($urandom,
                     ($urandom_range(0, 1) != 0) ? AREA_W'($urandom_range(2, 16)) :
                                                    AREA_W'($urandom_range(2, 1024)),
                     ($urandom_range(0, 1) != 0) ? MAXOP_W'($urandom_range(1, 4)) :
                                                    MAXOP_W'($urandom_range(1, 30)));
        end
      endcase
      run_groups(45);
      drain();
    end

    $display("Covered %0d items, %0d results and %0d group commits over %0d register settings",
             items_seen, results_seen, commits_seen, settings_used);
    $display("incl. full table, open-counter limit, wrapped slots and a two-block log area");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
